>>> hdl/dpcs_pkg.sv
// Shared constants, widths and register indexes for the drive position controller.
`default_nettype none
package dpcs_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 12;
   localparam int POS_WIDTH_DEF      = 20;

   localparam int SPEED_WIDTH = 8;
   localparam int GAIN_WIDTH  = 16;
   localparam int MAXSP_WIDTH = 7;
   localparam int RANGE_WIDTH = 16;
   localparam int STIME_WIDTH = 16;
   localparam int CNT_WIDTH   = 17;
   localparam int TICK_WIDTH  = 8;
   localparam int CSR_AWIDTH  = 3;

   localparam logic [GAIN_WIDTH-1:0]  GAIN_RST  = GAIN_WIDTH'(573);
   localparam logic [MAXSP_WIDTH-1:0] MAXSP_RST = MAXSP_WIDTH'(100);
   localparam logic [RANGE_WIDTH-1:0] RANGE_RST = RANGE_WIDTH'(10);
   localparam logic [STIME_WIDTH-1:0] STIME_RST = STIME_WIDTH'(300);

   typedef enum logic [CSR_AWIDTH-1:0] {
      REG_TARGET = 3'd0,
      REG_GAIN   = 3'd1,
      REG_MAXSP  = 3'd2,
      REG_RANGE  = 3'd3,
      REG_STIME  = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } item_kind_type;

endpackage
`default_nettype wire

>>> hdl/dpcs_side.sv
// Speed update for one wheel side: slew-limited rise, truncated proportional term, clamp.
`default_nettype none
module dpcs_side #(
   parameter int GAIN_FRAC_BITS = dpcs_pkg::GAIN_FRAC_BITS_DEF,
   parameter int POS_WIDTH      = dpcs_pkg::POS_WIDTH_DEF
) (
   input  wire logic signed [dpcs_pkg::SPEED_WIDTH-1:0] speed_i,
   input  wire logic signed [POS_WIDTH:0]               err_i,
   input  wire logic        [dpcs_pkg::GAIN_WIDTH-1:0]  gain_i,
   input  wire logic        [dpcs_pkg::MAXSP_WIDTH-1:0] max_speed_i,
   output logic signed      [dpcs_pkg::SPEED_WIDTH-1:0] speed_o
);
   import dpcs_pkg::*;

   localparam int ERR_W  = POS_WIDTH + 1;
   localparam int PROD_W = ERR_W + GAIN_WIDTH + 1;
   localparam int Q_W    = PROD_W - GAIN_FRAC_BITS;

   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W-1:0]      scaled;
   logic        [PROD_W-1:0]      mag;
   logic        [Q_W-1:0]         q;
   logic        [MAXSP_WIDTH-1:0] q_sel;
   logic signed [SPEED_WIDTH:0]   inc;
   logic signed [SPEED_WIDTH:0]   lim;
   logic signed [SPEED_WIDTH:0]   lim_neg;
   logic signed [SPEED_WIDTH:0]   mag_ext;

   always_comb begin
      prod    = PROD_W'(err_i) * PROD_W'($signed({1'b0, gain_i}));
      scaled  = PROD_W'(speed_i) <<< GAIN_FRAC_BITS;
      mag     = prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
      q       = Q_W'(mag >> GAIN_FRAC_BITS);
      lim     = $signed({2'b00, max_speed_i});
      lim_neg = -lim;
      inc     = $signed({speed_i[SPEED_WIDTH-1], speed_i}) + $signed((SPEED_WIDTH+1)'(1));
      q_sel   = (q > Q_W'(max_speed_i)) ? max_speed_i : q[MAXSP_WIDTH-1:0];
      mag_ext = $signed({2'b00, q_sel});
      if (prod > scaled) begin
         if (inc > lim) begin
            speed_o = lim[SPEED_WIDTH-1:0];
         end else if (inc < lim_neg) begin
            speed_o = lim_neg[SPEED_WIDTH-1:0];
         end else begin
            speed_o = inc[SPEED_WIDTH-1:0];
         end
      end else if (prod[PROD_W-1]) begin
         speed_o = SPEED_WIDTH'(-mag_ext);
      end else begin
         speed_o = mag_ext[SPEED_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

>>> hdl/dpcs_in_stage.sv
// Input register stage: takes an item and stores both position errors against the target.
`default_nettype none
module dpcs_in_stage #(
   parameter int POS_WIDTH = dpcs_pkg::POS_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid_i,
   output logic                                    in_ready_o,
   input  wire logic                               kind_i,
   input  wire logic signed [POS_WIDTH-1:0]        left_pos_i,
   input  wire logic signed [POS_WIDTH-1:0]        right_pos_i,
   input  wire logic [dpcs_pkg::TICK_WIDTH-1:0]    tick_i,
   input  wire logic signed [POS_WIDTH-1:0]        target_i,
   input  wire logic                               take_i,
   output logic                                    valid_o,
   output logic                                    kind_o,
   output logic signed [POS_WIDTH:0]               lerr_o,
   output logic signed [POS_WIDTH:0]               rerr_o,
   output logic [dpcs_pkg::TICK_WIDTH-1:0]         tick_o
);
   import dpcs_pkg::*;

   logic                      valid_ff, valid_in;
   logic                      kind_ff;
   logic signed [POS_WIDTH:0] lerr_ff, rerr_ff;
   logic [TICK_WIDTH-1:0]     tick_ff;
   logic                      load;

   assign in_ready_o = !valid_ff || take_i;
   assign load       = in_valid_i && in_ready_o;
   assign valid_in   = load || (valid_ff && !take_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_i;
         lerr_ff <= (POS_WIDTH+1)'(target_i) - (POS_WIDTH+1)'(left_pos_i);
         rerr_ff <= (POS_WIDTH+1)'(target_i) - (POS_WIDTH+1)'(right_pos_i);
         tick_ff <= tick_i;
      end
   end

   assign valid_o = valid_ff;
   assign kind_o  = kind_ff;
   assign lerr_o  = lerr_ff;
   assign rerr_o  = rerr_ff;
   assign tick_o  = tick_ff;

endmodule
`default_nettype wire

>>> hdl/drive_p_control_slew_settle.sv
// Top level of the two-sided proportional drive controller with slew limit and settle timer.
// Usage: each req item is a start (tuser 0) or a control tick (tuser 1) carrying both
// encoder positions and the milliseconds since the previous tick. Every item yields
// exactly one rsp item with both drive commands, the left error and the done flag.
// Configuration registers (target, gain, max speed, settle range, settle time) are
// written through the csr port while no item is in flight.
// From acceptance to rsp_tvalid an item passes one input register that forms
// the errors, then the speed, settle and done update into the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// multiply-compare path of each side sets the clock period.
// When the receiver stalls, the result register holds and the input register still
// takes one more item; req_tready falls only when both registers are full.
// Reset clears the speeds, the settle counter, the done flag and both valid flags,
// and loads the configuration registers with their reset values.
`default_nettype none
module drive_p_control_slew_settle #(
   parameter int GAIN_FRAC_BITS = dpcs_pkg::GAIN_FRAC_BITS_DEF,
   parameter int POS_WIDTH      = dpcs_pkg::POS_WIDTH_DEF,
   parameter int REQ_DW         = ((2 * POS_WIDTH + dpcs_pkg::TICK_WIDTH + 7) / 8) * 8,
   parameter int RSP_DW         = ((POS_WIDTH + 2 * dpcs_pkg::SPEED_WIDTH + 2 + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // left_position, right_position, tick_ms, zero fill
   input  wire logic [REQ_DW-1:0]                  req_tdata,
   // kind
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // left_drive, right_drive, left_error, done_res, zero fill
   output logic [RSP_DW-1:0]                       rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [dpcs_pkg::CSR_AWIDTH-1:0]    csr_addr,
   input  wire logic [POS_WIDTH-1:0]               csr_wdata
);
   import dpcs_pkg::*;

   localparam int RSP_USED = POS_WIDTH + 2 * SPEED_WIDTH + 2;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};

   logic signed [POS_WIDTH-1:0]   target_ff;
   logic [GAIN_WIDTH-1:0]         gain_ff;
   logic [MAXSP_WIDTH-1:0]        maxsp_ff;
   logic [RANGE_WIDTH-1:0]        range_ff;
   logic [STIME_WIDTH-1:0]        stime_ff;

   logic signed [SPEED_WIDTH-1:0] lspeed_ff, lspeed_in, rspeed_ff, rspeed_in;
   logic [CNT_WIDTH-1:0]          count_ff, count_in;
   logic                          done_ff, done_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED-1:0]           rsp_data_ff, rsp_data_in;

   logic                          s1_valid, s1_kind, s1_take;
   logic signed [POS_WIDTH:0]     s1_lerr, s1_rerr;
   logic [TICK_WIDTH-1:0]         s1_tick;
   logic signed [SPEED_WIDTH-1:0] lspeed_new, rspeed_new;
   logic signed [SPEED_WIDTH-1:0] ldrive, rdrive;
   logic [CNT_WIDTH:0]            count_sum;
   logic [CNT_WIDTH-1:0]          count_sat;
   logic [POS_WIDTH:0]            lerr_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         gain_ff   <= GAIN_RST;
         maxsp_ff  <= MAXSP_RST;
         range_ff  <= RANGE_RST;
         stime_ff  <= STIME_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TARGET: target_ff <= csr_wdata;
            REG_GAIN:   gain_ff   <= csr_wdata[GAIN_WIDTH-1:0];
            REG_MAXSP:  maxsp_ff  <= csr_wdata[MAXSP_WIDTH-1:0];
            REG_RANGE:  range_ff  <= csr_wdata[RANGE_WIDTH-1:0];
            REG_STIME:  stime_ff  <= csr_wdata[STIME_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign s1_take = s1_valid && (!rsp_valid_ff || rsp_tready);

   dpcs_in_stage #(.POS_WIDTH(POS_WIDTH)) u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid_i  (req_tvalid),
      .in_ready_o  (req_tready),
      .kind_i      (req_tuser),
      .left_pos_i  (req_tdata[POS_WIDTH-1:0]),
      .right_pos_i (req_tdata[2*POS_WIDTH-1:POS_WIDTH]),
      .tick_i      (req_tdata[2*POS_WIDTH+TICK_WIDTH-1:2*POS_WIDTH]),
      .target_i    (target_ff),
      .take_i      (s1_take),
      .valid_o     (s1_valid),
      .kind_o      (s1_kind),
      .lerr_o      (s1_lerr),
      .rerr_o      (s1_rerr),
      .tick_o      (s1_tick)
   );

   dpcs_side #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .POS_WIDTH(POS_WIDTH)) u_side_left (
      .speed_i     (lspeed_ff),
      .err_i       (s1_lerr),
      .gain_i      (gain_ff),
      .max_speed_i (maxsp_ff),
      .speed_o     (lspeed_new)
   );

   dpcs_side #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .POS_WIDTH(POS_WIDTH)) u_side_right (
      .speed_i     (rspeed_ff),
      .err_i       (s1_rerr),
      .gain_i      (gain_ff),
      .max_speed_i (maxsp_ff),
      .speed_o     (rspeed_new)
   );

   always_comb begin
      count_sum = {1'b0, count_ff} + (CNT_WIDTH+1)'(s1_tick);
      count_sat = count_sum[CNT_WIDTH] ? CNT_MAX : count_sum[CNT_WIDTH-1:0];
      lerr_mag  = s1_lerr[POS_WIDTH] ? $unsigned(-s1_lerr) : $unsigned(s1_lerr);

      lspeed_in = lspeed_ff;
      rspeed_in = rspeed_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      ldrive    = '0;
      rdrive    = '0;
      if (s1_kind == KIND_START) begin
         lspeed_in = '0;
         rspeed_in = '0;
         count_in  = '0;
         done_in   = 1'b0;
      end else if (!done_ff) begin
         lspeed_in = lspeed_new;
         rspeed_in = rspeed_new;
         count_in  = (lerr_mag > (POS_WIDTH+1)'(range_ff)) ? '0 : count_sat;
         done_in   = count_in > CNT_WIDTH'(stime_ff);
         if (!done_in) begin
            ldrive = lspeed_new;
            rdrive = rspeed_new;
         end
      end
      rsp_data_in  = {done_in, s1_lerr, rdrive, ldrive};
      rsp_valid_in = s1_take || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lspeed_ff    <= '0;
         rspeed_ff    <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_take) begin
            lspeed_ff <= lspeed_in;
            rspeed_ff <= rspeed_in;
            count_ff  <= count_in;
            done_ff   <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(rsp_data_ff);

   a_done_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[RSP_USED-1] |-> rsp_data_ff[2*SPEED_WIDTH-1:0] == '0)
      else $error("done result carries a nonzero drive");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid && rsp_valid_ff && !rsp_tready |=> s1_valid)
      else $error("input stage item dropped under stall");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      s1_take && s1_kind == KIND_START |=> !done_ff && count_ff == '0)
      else $error("start item did not clear the settle state");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid && rsp_valid_ff)
      else $error("input stalled while a stage is free");

endmodule
`default_nettype wire
